/* sv/htfd_pkg.sv */
`timescale 1ns / 1ps

package htfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned TEMP_W  = 9;
  localparam int unsigned HUM_W   = 7;

  localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT   = 8'hFF;
  localparam logic [BYTE_W-1:0] T_SCALE    = 8'd175;
  localparam logic [HUM_W-1:0]  H_SCALE    = 7'd100;
  localparam logic signed [TEMP_W-1:0] T_OFFSET = 9'sd45;

  // Position of the next expected byte in the reply frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TEMP_CRC = 2'd1,
    ST_HUM_CRC  = 2'd2,
    ST_BUS_ERR  = 2'd3
  } status_e;

  // Bytewise CRC-8, MSB first
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* sv/htfd_in_if.sv */
`timescale 1ns / 1ps

interface htfd_in_if import htfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              bus_error;

  modport source (output valid, output rx_byte, output bus_error, input ready);
  modport sink   (input valid, input rx_byte, input bus_error, output ready);
endinterface

/* sv/htfd_out_if.sv */
`timescale 1ns / 1ps

interface htfd_out_if import htfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_c;
  logic [HUM_W-1:0]         humidity_pct;
  status_e                  status;

  modport source (output valid, output temperature_c, output humidity_pct,
                  output status, input ready);
  modport sink   (input valid, input temperature_c, input humidity_pct,
                  input status, output ready);
endinterface

/* sv/htfd_scale.sv */
`timescale 1ns / 1ps

module htfd_scale import htfd_pkg::*; (
  input  logic [WORD_W-1:0]        temp_word_i,
  input  logic [WORD_W-1:0]        hum_word_i,
  output logic signed [TEMP_W-1:0] temperature_c_o,
  output logic [HUM_W-1:0]         humidity_pct_o
);

  localparam int unsigned TPROD_W = WORD_W + BYTE_W;
  localparam int unsigned HPROD_W = WORD_W + HUM_W;

  logic [TPROD_W-1:0] temp_prod;
  logic [HPROD_W-1:0] hum_prod;
  logic [BYTE_W-1:0]  temp_deg;

  // Keep the integer part of raw * scale / 2^16
  assign temp_prod = TPROD_W'(temp_word_i) * TPROD_W'(T_SCALE);
  assign hum_prod  = HPROD_W'(hum_word_i) * HPROD_W'(H_SCALE);
  assign temp_deg  = temp_prod[TPROD_W-1:WORD_W];

  assign temperature_c_o = $signed({1'b0, temp_deg}) - T_OFFSET;
  assign humidity_pct_o  = hum_prod[HPROD_W-1:WORD_W];

endmodule

/* sv/humidity_temp_frame_decoder.sv */
`timescale 1ns / 1ps
// Result: a result item is valid in the cycle after the sixth byte of a frame (or any
//   byte flagged with a bus error) is accepted; other bytes give no result.
// Throughput: one byte item per cycle; a held result stalls input only if the sink
//   is not ready, since the result register is refilled in the cycle it drains.
// Reset: rst_ni low clears the frame position, loads the CRC with 0xFF, clears
//   the stored words and the temperature check flag, and empties the result register.

module humidity_temp_frame_decoder import htfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  htfd_in_if.sink    in_i,
  htfd_out_if.source out_o
);

  // Frame state
  pos_e              pos_q, pos_d;
  logic [BYTE_W-1:0] crc_q, crc_d;
  logic [WORD_W-1:0] temp_word_q, temp_word_d;
  logic [WORD_W-1:0] hum_word_q, hum_word_d;
  logic              temp_ok_q, temp_ok_d;

  // Result register
  logic                     out_valid_q;
  logic signed [TEMP_W-1:0] out_temp_q, out_temp_d;
  logic [HUM_W-1:0]         out_hum_q, out_hum_d;
  status_e                  out_status_q, out_status_d;
  logic                     emit_d;

  logic                     in_fire;
  logic [BYTE_W-1:0]        crc_base;
  logic [BYTE_W-1:0]        crc_next;
  logic signed [TEMP_W-1:0] scaled_temp;
  logic [HUM_W-1:0]         scaled_hum;

  // Take a new item whenever the result register is empty or drains this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // A frame's first byte starts from the CRC seed; unused positions count as first
  assign crc_base = (pos_q == POS_T_LO || pos_q == POS_H_HI || pos_q == POS_H_LO) ?
                    crc_q : CRC_INIT;
  assign crc_next = crc8_update(crc_base, in_i.rx_byte);

  htfd_scale u_scale (
    .temp_word_i     (temp_word_q),
    .hum_word_i      (hum_word_q),
    .temperature_c_o (scaled_temp),
    .humidity_pct_o  (scaled_hum)
  );

  // Next frame position
  always_comb begin
    if (in_i.bus_error) begin
      pos_d = POS_T_HI;
    end else begin
      case (pos_q)
        POS_T_HI:  pos_d = POS_T_LO;
        POS_T_LO:  pos_d = POS_T_CRC;
        POS_T_CRC: pos_d = POS_H_HI;
        POS_H_HI:  pos_d = POS_H_LO;
        POS_H_LO:  pos_d = POS_H_CRC;
        POS_H_CRC: pos_d = POS_T_HI;
        default:   pos_d = POS_T_LO;
      endcase
    end
  end

  // Datapath and result for the byte at the input
  always_comb begin
    crc_d        = crc_q;
    temp_word_d  = temp_word_q;
    hum_word_d   = hum_word_q;
    temp_ok_d    = temp_ok_q;
    emit_d       = 1'b0;
    out_temp_d   = '0;
    out_hum_d    = '0;
    out_status_d = ST_OK;
    if (in_i.bus_error) begin
      // Abort the frame and report at once
      crc_d        = CRC_INIT;
      emit_d       = 1'b1;
      out_status_d = ST_BUS_ERR;
    end else begin
      case (pos_q)
        POS_T_LO: begin
          crc_d       = crc_next;
          temp_word_d = {temp_word_q[WORD_W-1:BYTE_W], in_i.rx_byte};
        end
        POS_T_CRC: begin
          temp_ok_d = (crc_q == in_i.rx_byte);
          crc_d     = CRC_INIT;
        end
        POS_H_HI: begin
          crc_d      = crc_next;
          hum_word_d = {in_i.rx_byte, {BYTE_W{1'b0}}};
        end
        POS_H_LO: begin
          crc_d      = crc_next;
          hum_word_d = {hum_word_q[WORD_W-1:BYTE_W], in_i.rx_byte};
        end
        POS_H_CRC: begin
          // Temperature check wins when both words fail
          crc_d  = CRC_INIT;
          emit_d = 1'b1;
          if (!temp_ok_q) begin
            out_status_d = ST_TEMP_CRC;
          end else if (crc_q != in_i.rx_byte) begin
            out_status_d = ST_HUM_CRC;
          end else begin
            out_temp_d = scaled_temp;
            out_hum_d  = scaled_hum;
          end
        end
        default: begin
          crc_d       = crc_next;
          temp_word_d = {in_i.rx_byte, {BYTE_W{1'b0}}};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_T_HI;
      crc_q       <= CRC_INIT;
      temp_word_q <= '0;
      hum_word_q  <= '0;
      temp_ok_q   <= 1'b0;
    end else if (in_fire) begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
      temp_ok_q   <= temp_ok_d;
    end
  end

  // Result valid: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold until the next emitting item
  always_ff @(posedge clk_i) begin
    if (in_fire && emit_d) begin
      out_temp_q   <= out_temp_d;
      out_hum_q    <= out_hum_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.temperature_c = out_temp_q;
  assign out_o.humidity_pct  = out_hum_q;
  assign out_o.status        = out_status_q;

  // A failed frame carries zero readings
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK |-> out_temp_q == '0 && out_hum_q == '0)
    else $error("failed frame result carries nonzero readings");

  // A good frame stays within the sensor's scaled range
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == ST_OK |->
      out_temp_q >= -T_OFFSET && out_hum_q < H_SCALE)
    else $error("scaled reading out of range");

  // A bus error restarts the frame
  a_err_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.bus_error |=> pos_q == POS_T_HI && crc_q == CRC_INIT)
    else $error("bus error did not restart the frame");

  // A result appears only after an accepted item
  a_rise_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire))
    else $error("result appeared without an accepted item");

  // Mid-frame bytes without error produce no result
  a_quiet_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.bus_error && pos_q != POS_H_CRC |=> !out_valid_q)
    else $error("result emitted mid-frame");

endmodule

/* test/htfd_tb_pkg.sv */
`timescale 1ns / 1ps

package htfd_tb_pkg;
  import htfd_pkg::*;

  // Shift one byte through the CRC-8 register bit by bit, MSB first
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb  = crc[BYTE_W-1] ^ b[i];
      crc = {crc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return crc;
  endfunction

  function automatic logic [BYTE_W-1:0] word_crc(input logic [WORD_W-1:0] w);
    return crc8_feed(crc8_feed(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

endpackage

/* test/htfd_reading_checker.sv */
`timescale 1ns / 1ps

module htfd_reading_checker import htfd_pkg::*, htfd_tb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  htfd_in_if   byte_if,
  htfd_out_if  result_if,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_c;
    logic [HUM_W-1:0]         humidity_pct;
    status_e                  status;
  } reading_t;

  localparam int unsigned MAX_PRINTED = 100;

  reading_t          expected_readings[$];
  pos_e              frame_pos;
  logic [BYTE_W-1:0] running_crc;
  logic [WORD_W-1:0] temp_raw;
  logic [WORD_W-1:0] hum_raw;
  logic              temp_ok;

  initial fail_count_o = 0;

  task automatic flag(input string what);
    fail_count_o++;
    if (fail_count_o <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic reading_t error_reading(input status_e st);
    reading_t r;
    r.temperature_c = '0;
    r.humidity_pct  = '0;
    r.status        = st;
    return r;
  endfunction

  function automatic reading_t scaled_reading(input logic [WORD_W-1:0] tw,
                                              input logic [WORD_W-1:0] hw);
    reading_t    r;
    logic [31:0] t_prod;
    logic [31:0] h_prod;
    t_prod          = 32'(tw) * 32'(T_SCALE);
    h_prod          = 32'(hw) * 32'(H_SCALE);
    r.temperature_c = TEMP_W'(t_prod[31:16]) - T_OFFSET;
    r.humidity_pct  = h_prod[16 +: HUM_W];
    r.status        = ST_OK;
    return r;
  endfunction

  // Advance the frame state by one byte; queue the reading it yields, if any
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic err);
    logic hum_ok;
    if (err) begin
      frame_pos   = POS_T_HI;
      running_crc = CRC_INIT;
      expected_readings.push_back(error_reading(ST_BUS_ERR));
    end else begin
      case (frame_pos)
        POS_T_LO: begin
          running_crc   = crc8_feed(running_crc, b);
          temp_raw[7:0] = b;
          frame_pos     = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_ok     = (running_crc == b);
          running_crc = CRC_INIT;
          frame_pos   = POS_H_HI;
        end
        POS_H_HI: begin
          running_crc = crc8_feed(running_crc, b);
          hum_raw     = {b, 8'h00};
          frame_pos   = POS_H_LO;
        end
        POS_H_LO: begin
          running_crc  = crc8_feed(running_crc, b);
          hum_raw[7:0] = b;
          frame_pos    = POS_H_CRC;
        end
        POS_H_CRC: begin
          hum_ok      = (running_crc == b);
          frame_pos   = POS_T_HI;
          running_crc = CRC_INIT;
          // temperature check wins when both words are bad
          if (!temp_ok) expected_readings.push_back(error_reading(ST_TEMP_CRC));
          else if (!hum_ok) expected_readings.push_back(error_reading(ST_HUM_CRC));
          else expected_readings.push_back(scaled_reading(temp_raw, hum_raw));
        end
        default: begin
          running_crc = crc8_feed(CRC_INIT, b);
          temp_raw    = {b, 8'h00};
          frame_pos   = POS_T_LO;
        end
      endcase
    end
  endtask

  task automatic compare_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      flag("result item with nothing expected");
      return;
    end
    want = expected_readings.pop_front();
    if (result_if.temperature_c !== want.temperature_c)
      flag($sformatf("temperature_c got %0d, want %0d",
                     result_if.temperature_c, want.temperature_c));
    if (result_if.humidity_pct !== want.humidity_pct)
      flag($sformatf("humidity_pct got %0d, want %0d",
                     result_if.humidity_pct, want.humidity_pct));
    if (result_if.status !== want.status)
      flag($sformatf("status got %0d, want %0d", result_if.status, want.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pos   = POS_T_HI;
      running_crc = CRC_INIT;
      temp_raw    = '0;
      hum_raw     = '0;
      temp_ok     = 1'b0;
      expected_readings.delete();
      pending_o <= 0;
    end else begin
      if (result_if.valid && result_if.ready) compare_reading();
      if (byte_if.valid && byte_if.ready) decode_byte(byte_if.rx_byte, byte_if.bus_error);
      pending_o <= expected_readings.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

// Sensor reply decoder test: feed six-byte frames (temperature word, CRC,
// humidity word, CRC) plus stray bytes and bus errors, and let the checker
// predict each reading and compare it with what the decoder emits.
module testbench;
  import htfd_pkg::*;
  import htfd_tb_pkg::*;

  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int          NO_ABORT     = -1;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          pending;
  bit          no_idle;
  int unsigned bytes_sent;

  htfd_in_if  byte_if();
  htfd_out_if result_if();

  humidity_temp_frame_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (result_if)
  );

  htfd_reading_checker check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_if      (byte_if),
    .result_if    (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: the slowest legal run stays far below this
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: hold ready low for a random stall before each item, or not at
  // all while a no-idle stretch is running.
  initial begin
    int unsigned stall;
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  // Send one byte item after a random gap; keep valid high straight into the
  // next item when there is no gap.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic err);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.rx_byte   <= b;
    byte_if.bus_error <= err;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  // Send a whole reply frame. Corrupt either CRC on request; abort_at names
  // the byte that carries a bus error instead (the frame stops there).
  task automatic push_frame(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] hw,
                            input logic t_bad, input logic h_bad, input int abort_at);
    logic [BYTE_W-1:0] frame_bytes [6];
    logic [BYTE_W-1:0] tc;
    logic [BYTE_W-1:0] hc;
    tc = word_crc(tw);
    hc = word_crc(hw);
    if (t_bad) tc ^= BYTE_W'($urandom_range(1, 255));
    if (h_bad) hc ^= BYTE_W'($urandom_range(1, 255));
    frame_bytes = '{tw[15:8], tw[7:0], tc, hw[15:8], hw[7:0], hc};
    for (int i = 0; i < 6; i++) begin
      if (i == abort_at) begin
        push_byte(BYTE_W'($urandom), 1'b1);
        return;
      end
      push_byte(frame_bytes[i], 1'b0);
    end
  endtask

  // Drop valid and hold until every queued reading has come out
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Favor the word extremes so the scaling ends get hit often
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned random_start;
    bit          paused;
    int          abort_at;

    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.rx_byte   <= '0;
    byte_if.bus_error <= 1'b0;
    no_idle    = 1'b0;
    bytes_sent = 0;
    paused     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: coldest/driest and hottest/wettest readings, a frame with both
    // CRCs bad (temperature status wins), a humidity-only CRC failure, a bus
    // error on a frame's first byte and one in the middle of a frame.
    push_frame(16'h0000, 16'h0000, 1'b0, 1'b0, NO_ABORT);
    push_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, NO_ABORT);
    push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, NO_ABORT);
    push_frame(16'h6666, 16'h9999, 1'b0, 1'b1, NO_ABORT);
    push_byte(8'hFF, 1'b1);
    push_frame(16'hA5A5, 16'h5A5A, 1'b0, 1'b0, 3);

    // Random: mostly well-formed frames with random words, some with bad CRCs
    // or an aborting bus error; the rest stray bytes that knock frames out of
    // step. Toggle no-idle stretches now and then.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 3) no_idle = ~no_idle;
      if (!paused && bytes_sent - random_start > RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        abort_at = ($urandom_range(0, 99) < 6) ? int'($urandom_range(0, 5)) : NO_ABORT;
        push_frame(pick_word(), pick_word(), $urandom_range(0, 99) < 10,
                   $urandom_range(0, 99) < 10, abort_at);
      end else begin
        push_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* humidity_temp_frame_decoder.f */
sv/htfd_pkg.sv
sv/htfd_in_if.sv
sv/htfd_out_if.sv
sv/htfd_scale.sv
sv/humidity_temp_frame_decoder.sv
test/htfd_tb_pkg.sv
test/htfd_reading_checker.sv
test/testbench.sv
